### sv/rfgi_pkg.sv
package rfgi_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FADE_IN_FRAMES  = 3'd0;
  localparam logic [2:0] REG_FADE_IN_SHAPE   = 3'd1;
  localparam logic [2:0] REG_FADE_OUT_FRAMES = 3'd2;
  localparam logic [2:0] REG_FADE_OUT_SHAPE  = 3'd3;
  localparam logic [2:0] REG_REGION_FRAMES   = 3'd4;
  localparam logic [2:0] REG_REGION_GAIN     = 3'd5;

  // Fade curve codes
  localparam logic [1:0] SHAPE_LINEAR    = 2'd0;
  localparam logic [1:0] SHAPE_EQ_POWER  = 2'd1;
  localparam logic [1:0] SHAPE_SCURVE    = 2'd2;

  // Q16 and Q30 constants
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [17:0] REGION_GAIN_RESET = 18'd65536;

  // Fade divider steps (one quotient bit per stage)
  localparam int DIV_STEPS = 16;

endpackage

### sv/region_fade_gain_interpolator_core.sv
// Region fade and gain stage for one stereo timeline frame.
//
// Input: pulse start with the frame position, the two adjacent source frames
// of each channel and the interpolation fraction; a word is taken at every
// clock edge where start is high (busy is always low, so a word may enter in
// every cycle). Output: out_valid marks left/right results for exactly one
// cycle; the receiver takes them then, there is no back-pressure.
// Configuration: cfg_we/cfg_index/cfg_wdata write the six registers (fade-in
// length and shape, fade-out length and shape, region length, region gain).
// The user writes them only while no word is in flight; the block does not
// enforce it. Throughput: one word per cycle. The fade position divider is a
// 16-stage restoring divider producing one quotient bit a stage, followed by
// the curve, sine table, gain and scaling stages.
// Reset (synchronous, rst_n low) clears all valid bits and loads register
// defaults: fades disabled, region length zero, region gain 1.0.
module region_fade_gain_interpolator_core
  import rfgi_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   in_frame_index,
  input  logic signed [SAMPLE_BITS-1:0] in_left_now,
  input  logic signed [SAMPLE_BITS-1:0] in_left_next,
  input  logic signed [SAMPLE_BITS-1:0] in_right_now,
  input  logic signed [SAMPLE_BITS-1:0] in_right_next,
  input  logic [15:0]                   in_frac,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  localparam int SINE_N = 1 << SINE_TABLE_BITS;
  localparam int SH     = 16 - SINE_TABLE_BITS;
  localparam int IW     = SINE_TABLE_BITS + 1;
  localparam int SW     = SAMPLE_BITS + 1;
  localparam int IPW    = SW + 17;
  localparam int OPW    = SW + 19;
  localparam int EQW    = 17 + SH + 1;
  localparam int NDLY   = 23;

  localparam logic signed [OPW-1:0] MAXV = OPW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [OPW-1:0] MINV = -MAXV - OPW'(1);

  typedef logic [16:0] sine_tab_t [SINE_N+1];

  // Quarter sine in Q1.16 from a Taylor series in Q2.30
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int k = 0; k <= SINE_N; k++) begin
      x    = (longint'(k) * HALF_PI_Q30 + longint'(SINE_N / 2)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int j = 1; j <= 6; j++) begin
        term = (term * x2) >> 30;
        case (j)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          default: term = term / 156;
        endcase
        if ((j & 1) == 1) sum = sum - longint'(term);
        else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) >>> 14;
      if (sum > 65536) sum = 65536;
      tab[k] = 17'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  assign busy = 1'b0;

  // ---------------------------------------------------------------- config
  logic [23:0] fade_in_frames_r, fade_out_frames_r;
  logic [1:0]  fade_in_shape_r, fade_out_shape_r;
  logic [31:0] region_frames_r;
  logic [17:0] region_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_in_frames_r  <= '0;
      fade_in_shape_r   <= SHAPE_LINEAR;
      fade_out_frames_r <= '0;
      fade_out_shape_r  <= SHAPE_LINEAR;
      region_frames_r   <= '0;
      region_gain_r     <= REGION_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FADE_IN_FRAMES:  fade_in_frames_r  <= cfg_wdata[23:0];
        REG_FADE_IN_SHAPE:   fade_in_shape_r   <= cfg_wdata[1:0];
        REG_FADE_OUT_FRAMES: fade_out_frames_r <= cfg_wdata[23:0];
        REG_FADE_OUT_SHAPE:  fade_out_shape_r  <= cfg_wdata[1:0];
        REG_REGION_FRAMES:   region_frames_r   <= cfg_wdata;
        REG_REGION_GAIN:     region_gain_r     <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  logic [23:0] den [2];
  logic [1:0]  shp [2];
  assign den[0] = fade_in_frames_r;
  assign den[1] = fade_out_frames_r;
  assign shp[0] = fade_in_shape_r;
  assign shp[1] = fade_out_shape_r;

  // ---------------------------------------------------------------- valid chain
  // v_r[k] is the valid bit of stage k+1
  logic [25:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[24:0], start & ~busy};
  end

  // ---------------------------------------------------------------- stage 1: input word
  logic [31:0]                   idx1_r;
  logic signed [SAMPLE_BITS-1:0] ln1_r, lx1_r, rn1_r, rx1_r;
  logic [15:0]                   fr1_r;
  always_ff @(posedge clk) begin
    idx1_r <= in_frame_index;
    ln1_r  <= in_left_now;
    lx1_r  <= in_left_next;
    rn1_r  <= in_right_now;
    rx1_r  <= in_right_next;
    fr1_r  <= in_frac;
  end

  // ---------------------------------------------------------------- stage 2: positions, interp
  logic signed [33:0] fo_start, fo_d;
  logic               fi_act_nxt, fo_act_nxt, fo_zero_nxt;
  always_comb begin
    fo_start    = $signed({2'b00, region_frames_r}) - $signed({10'd0, fade_out_frames_r});
    fo_d        = $signed({2'b00, idx1_r}) - fo_start;
    fi_act_nxt  = (fade_in_frames_r != '0) && (idx1_r < {8'd0, fade_in_frames_r});
    fo_act_nxt  = (fade_out_frames_r != '0) && ($signed({2'b00, idx1_r}) >= fo_start);
    fo_zero_nxt = fo_d >= $signed({10'd0, fade_out_frames_r});
  end

  function automatic logic signed [SW-1:0] interp(input logic signed [SAMPLE_BITS-1:0] a,
                                                  input logic signed [SAMPLE_BITS-1:0] b,
                                                  input logic [15:0] f);
    logic signed [SW-1:0]  diff;
    logic signed [IPW-1:0] prod;
    logic signed [IPW-1:0] rnd;
    diff = SW'(b) - SW'(a);
    prod = IPW'($signed({1'b0, f})) * IPW'(diff);
    rnd  = (prod + IPW'(32768)) >>> 16;
    return SW'(a) + rnd[SW-1:0];
  endfunction

  logic signed [SW-1:0] samp_l_r [NDLY];
  logic signed [SW-1:0] samp_r_r [NDLY];

  // divider pipeline, index 0 is stage 2
  logic [23:0] div_rem_r [DIV_STEPS+1][2];
  logic [15:0] div_q_r   [DIV_STEPS+1][2];
  logic        div_act_r [DIV_STEPS+1][2];
  logic        div_zero_r[DIV_STEPS+1];

  always_ff @(posedge clk) begin
    samp_l_r[0]      <= interp(ln1_r, lx1_r, fr1_r);
    samp_r_r[0]      <= interp(rn1_r, rx1_r, fr1_r);
    div_rem_r[0][0]  <= idx1_r[23:0];
    div_rem_r[0][1]  <= fo_d[23:0];
    div_q_r[0][0]    <= '0;
    div_q_r[0][1]    <= '0;
    div_act_r[0][0]  <= fi_act_nxt;
    div_act_r[0][1]  <= fo_act_nxt;
    div_zero_r[0]    <= fo_zero_nxt;
  end

  // sample delay line alongside the gain path
  always_ff @(posedge clk) begin
    for (int k = 1; k < NDLY; k++) begin
      samp_l_r[k] <= samp_l_r[k-1];
      samp_r_r[k] <= samp_r_r[k-1];
    end
  end

  // ---------------------------------------------------------------- stages 3..18: divider
  // floor(d * 2^16 / den) with d < den, one quotient bit per stage
  for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
    for (genvar gf = 0; gf < 2; gf++) begin : g_fade
      logic [24:0] rem2;
      logic        ge;
      logic [23:0] rem_nxt;
      always_comb begin
        rem2    = {div_rem_r[gi][gf], 1'b0};
        ge      = rem2 >= {1'b0, den[gf]};
        rem_nxt = ge ? 24'(rem2 - {1'b0, den[gf]}) : rem2[23:0];
      end
      always_ff @(posedge clk) begin
        div_rem_r[gi+1][gf] <= rem_nxt;
        div_q_r[gi+1][gf]   <= {div_q_r[gi][gf][14:0], ge};
        div_act_r[gi+1][gf] <= div_act_r[gi][gf];
      end
    end
    always_ff @(posedge clk) div_zero_r[gi+1] <= div_zero_r[gi];
  end

  // ---------------------------------------------------------------- stage 19: fade position
  logic [16:0] t19_r   [2];
  logic        act19_r [2];
  always_ff @(posedge clk) begin
    t19_r[0]   <= {1'b0, div_q_r[DIV_STEPS][0]};
    t19_r[1]   <= div_zero_r[DIV_STEPS] ? 17'd0 : ONE_Q16 - {1'b0, div_q_r[DIV_STEPS][1]};
    act19_r[0] <= div_act_r[DIV_STEPS][0];
    act19_r[1] <= div_act_r[DIV_STEPS][1];
  end

  // ---------------------------------------------------------------- stages 20..22: curves
  logic [16:0]     rom_a_r [2], rom_b_r [2];
  logic [SH-1:0]   fr20_r  [2];
  logic [33:0]     sq20_r  [2];
  logic [16:0]     t20_r   [2];
  logic            act20_r [2];
  logic [17+SH-1:0] eq21_r [2];
  logic [16:0]     a21_r   [2];
  logic [34:0]     sc21_r  [2];
  logic [16:0]     t21_r   [2];
  logic            act21_r [2];
  logic [16:0]     g22_r   [2];

  for (genvar gf = 0; gf < 2; gf++) begin : g_curve
    logic [IW-1:0]  addr_a, addr_b;
    logic [16:0]    t2;
    logic [17:0]    fac;
    logic [EQW-1:0] eq_sum;
    logic [35:0]    sc_sum;
    logic [16:0]    g_nxt;

    // table addresses: entry below t and the one above, clamped at the top
    always_comb begin
      addr_a = t19_r[gf][16:SH];
      addr_b = (addr_a == IW'(SINE_N)) ? addr_a : addr_a + IW'(1);
    end

    always_ff @(posedge clk) begin
      rom_a_r[gf] <= SINE_TAB[addr_a];
      rom_b_r[gf] <= SINE_TAB[addr_b];
      fr20_r[gf]  <= t19_r[gf][SH-1:0];
      sq20_r[gf]  <= 34'(t19_r[gf]) * 34'(t19_r[gf]);
      t20_r[gf]   <= t19_r[gf];
      act20_r[gf] <= act19_r[gf];
    end

    // S-curve second product, equal-power slope product
    always_comb begin
      t2  = 17'((sq20_r[gf] + 34'd32768) >> 16);
      fac = 18'd196608 - {t20_r[gf], 1'b0};
    end

    always_ff @(posedge clk) begin
      eq21_r[gf]  <= (17 + SH)'(rom_b_r[gf] - rom_a_r[gf]) * (17 + SH)'(fr20_r[gf]);
      a21_r[gf]   <= rom_a_r[gf];
      sc21_r[gf]  <= 35'(t2) * 35'(fac);
      t21_r[gf]   <= t20_r[gf];
      act21_r[gf] <= act20_r[gf];
    end

    // curve select; an inactive fade or an undefined shape is unity
    always_comb begin
      eq_sum = (EQW'(eq21_r[gf]) + EQW'(1 << (SH - 1))) >> SH;
      sc_sum = (36'(sc21_r[gf]) + 36'd32768) >> 16;
      g_nxt  = ONE_Q16;
      if (act21_r[gf]) begin
        case (shp[gf])
          SHAPE_LINEAR:   g_nxt = t21_r[gf];
          SHAPE_EQ_POWER: g_nxt = a21_r[gf] + eq_sum[16:0];
          SHAPE_SCURVE:   g_nxt = sc_sum[16:0];
          default:        g_nxt = ONE_Q16;
        endcase
      end
    end

    always_ff @(posedge clk) g22_r[gf] <= g_nxt;
  end

  // ---------------------------------------------------------------- stages 23..24: gains
  logic [16:0] fade23_r;
  logic [17:0] gain24_r;
  logic [33:0] fade_prod;
  logic [35:0] gain_prod;
  always_comb begin
    fade_prod = 34'(g22_r[0]) * 34'(g22_r[1]);
    gain_prod = 36'(fade23_r) * 36'(region_gain_r);
  end
  always_ff @(posedge clk) begin
    fade23_r <= 17'((fade_prod + 34'd32768) >> 16);
    gain24_r <= 18'((gain_prod + 36'd32768) >> 16);
  end

  // ---------------------------------------------------------------- stages 25..26: scale, saturate
  logic signed [OPW-1:0] pl25_r, pr25_r;
  always_ff @(posedge clk) begin
    pl25_r <= OPW'(samp_l_r[NDLY-1]) * OPW'($signed({1'b0, gain24_r}));
    pr25_r <= OPW'(samp_r_r[NDLY-1]) * OPW'($signed({1'b0, gain24_r}));
  end

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [OPW-1:0] p);
    logic signed [OPW-1:0] y;
    y = (p + OPW'(32768)) >>> 16;
    if (y > MAXV) y = MAXV;
    if (y < MINV) y = MINV;
    return y[SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    out_left_out  <= round_sat(pl25_r);
    out_right_out <= round_sat(pr25_r);
  end

  assign out_valid = v_r[25];

  // ---------------------------------------------------------------- checks
  // fade-in divider remainder stays below the divisor for an active fade-in
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[17] && div_act_r[DIV_STEPS][0]) |-> (div_rem_r[DIV_STEPS][0] < den[0]))
    else $error("fade-in divider remainder out of range");

  // curve gains never exceed unity
  a_curve_unity: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[21] |-> ((g22_r[0] <= ONE_Q16) && (g22_r[1] <= ONE_Q16)))
    else $error("fade curve above unity");

  // combined fade never exceeds unity
  a_fade_unity: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[22] |-> (fade23_r <= ONE_Q16))
    else $error("fade gain above unity");

endmodule
